FILE: hdl/bpm_pkg.sv
// Shared types and constants for the battery pack monitor.
// Holds register indexes, register reset values and pack type codes.
// No dependencies.
package bpm_pkg;

    // Configuration registers are all this wide.
    localparam int unsigned REG_W     = 20;
    localparam int unsigned NUM_REGS  = 8;
    localparam int unsigned REG_IDX_W = 3;

    typedef logic [REG_W-1:0]     reg_word_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_UP_THRESHOLD   = 3'd0;
    localparam reg_idx_t REG_DOWN_THRESHOLD = 3'd1;
    localparam reg_idx_t REG_WARN_ONE_CELL  = 3'd2;
    localparam reg_idx_t REG_CRIT_ONE_CELL  = 3'd3;
    localparam reg_idx_t REG_WARN_TWO_CELL  = 3'd4;
    localparam reg_idx_t REG_CRIT_TWO_CELL  = 3'd5;
    localparam reg_idx_t REG_WARN_MARGIN    = 3'd6;
    localparam reg_idx_t REG_CRIT_MARGIN    = 3'd7;

    localparam reg_word_t RST_UP_THRESHOLD   = 20'd655360;
    localparam reg_word_t RST_DOWN_THRESHOLD = 20'd614400;
    localparam reg_word_t RST_WARN_ONE_CELL  = 20'd409600;
    localparam reg_word_t RST_CRIT_ONE_CELL  = 20'd358400;
    localparam reg_word_t RST_WARN_TWO_CELL  = 20'd819200;
    localparam reg_word_t RST_CRIT_TWO_CELL  = 20'd716800;
    localparam reg_word_t RST_WARN_MARGIN    = 20'd12800;
    localparam reg_word_t RST_CRIT_MARGIN    = 20'd12800;

    typedef enum logic [1:0] {
        PACK_UNKNOWN = 2'd0,
        PACK_ONE     = 2'd1,
        PACK_TWO     = 2'd2
    } pack_t;

endpackage

FILE: hdl/battery_pack_monitor_core.sv
// Top level of the battery pack monitor: moving-average filter, pack type
// decision and low-voltage flags with hysteresis.
// Depends on bpm_pkg.

// The block accepts one ADC sample per clock cycle while the result side is
// not stalled, and offers one result beat per sample. An accepted sample is
// held in an input register; once the output register is free or being read,
// the filter update (a shift, a subtract and an add), the pack decision and
// the flag comparisons are done in one pass and the result is loaded into the
// output register while the filter state moves on. The output register can
// hold one finished result while the next sample waits in the input register.
// Configuration registers are written through cfg_wr_en, cfg_index and
// cfg_wdata and should only change while no sample is in flight.
module battery_pack_monitor_core #(
    parameter int unsigned ADC_BITS    = 12,
    parameter int unsigned FRAC_BITS   = 8,
    parameter int unsigned ALPHA_SHIFT = 3
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  bpm_pkg::reg_idx_t                 cfg_index,
    input  bpm_pkg::reg_word_t                cfg_wdata,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ADC_BITS-1:0]               s_sample,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ADC_BITS-1:0]               m_raw_level,
    output logic [ADC_BITS+FRAC_BITS-1:0]     m_level,
    output logic [1:0]                        m_pack,
    output logic                              m_warn,
    output logic                              m_crit
);

    import bpm_pkg::*;

    localparam int unsigned LVL_W = ADC_BITS + FRAC_BITS;
    localparam int unsigned SUM_W = LVL_W + ALPHA_SHIFT + 1;
    localparam int unsigned CMP_W = ((LVL_W > REG_W) ? LVL_W : REG_W) + 1;

    // Configuration registers.
    reg_word_t up_thr_reg, down_thr_reg;
    reg_word_t warn_one_reg, crit_one_reg, warn_two_reg, crit_two_reg;
    reg_word_t warn_margin_reg, crit_margin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_thr_reg      <= RST_UP_THRESHOLD;
            down_thr_reg    <= RST_DOWN_THRESHOLD;
            warn_one_reg    <= RST_WARN_ONE_CELL;
            crit_one_reg    <= RST_CRIT_ONE_CELL;
            warn_two_reg    <= RST_WARN_TWO_CELL;
            crit_two_reg    <= RST_CRIT_TWO_CELL;
            warn_margin_reg <= RST_WARN_MARGIN;
            crit_margin_reg <= RST_CRIT_MARGIN;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_UP_THRESHOLD:   up_thr_reg      <= cfg_wdata;
                REG_DOWN_THRESHOLD: down_thr_reg    <= cfg_wdata;
                REG_WARN_ONE_CELL:  warn_one_reg    <= cfg_wdata;
                REG_CRIT_ONE_CELL:  crit_one_reg    <= cfg_wdata;
                REG_WARN_TWO_CELL:  warn_two_reg    <= cfg_wdata;
                REG_CRIT_TWO_CELL:  crit_two_reg    <= cfg_wdata;
                REG_WARN_MARGIN:    warn_margin_reg <= cfg_wdata;
                REG_CRIT_MARGIN:    crit_margin_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline control.
    logic                in_valid_reg;
    logic [ADC_BITS-1:0] in_sample_reg;
    logic                out_valid_reg;
    logic                advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_sample_reg <= s_sample;
        end
    end

    // Filter and decision state.
    logic [LVL_W-1:0] avg_reg, avg_next;
    pack_t            pack_reg, pack_next;
    logic             warn_reg, warn_next;
    logic             crit_reg, crit_next;

    logic [LVL_W-1:0] x_wide;
    logic [SUM_W-1:0] blend;
    logic [CMP_W-1:0] lvl_cmp;
    reg_word_t        warn_thr, crit_thr;
    logic [CMP_W-1:0] warn_lim, crit_lim;

    always_comb begin
        x_wide = LVL_W'(in_sample_reg) << FRAC_BITS;
        // average * (2^A - 1) + x, formed as a shift and subtract.
        blend  = (SUM_W'(avg_reg) << ALPHA_SHIFT) - SUM_W'(avg_reg) + SUM_W'(x_wide);

        if (avg_reg == '0) begin
            avg_next = x_wide;
        end else begin
            avg_next = LVL_W'(blend >> ALPHA_SHIFT);
        end

        lvl_cmp = CMP_W'(avg_next);

        priority if (avg_next == '0) begin
            pack_next = PACK_UNKNOWN;
        end else if (pack_reg == PACK_TWO) begin
            pack_next = (lvl_cmp <= CMP_W'(down_thr_reg)) ? PACK_ONE : PACK_TWO;
        end else begin
            pack_next = (lvl_cmp >= CMP_W'(up_thr_reg)) ? PACK_TWO : PACK_ONE;
        end

        if (pack_next == PACK_TWO) begin
            warn_thr = warn_two_reg;
            crit_thr = crit_two_reg;
        end else begin
            warn_thr = warn_one_reg;
            crit_thr = crit_one_reg;
        end

        // While a flag is set its release level is raised by the margin.
        warn_lim = CMP_W'(warn_thr) + (warn_reg ? CMP_W'(warn_margin_reg) : CMP_W'(0));
        crit_lim = CMP_W'(crit_thr) + (crit_reg ? CMP_W'(crit_margin_reg) : CMP_W'(0));

        if (pack_next == PACK_UNKNOWN) begin
            warn_next = 1'b1;
            crit_next = 1'b1;
        end else begin
            warn_next = lvl_cmp < warn_lim;
            crit_next = lvl_cmp < crit_lim;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg  <= '0;
            pack_reg <= PACK_UNKNOWN;
            warn_reg <= 1'b0;
            crit_reg <= 1'b0;
        end else if (advance) begin
            avg_reg  <= avg_next;
            pack_reg <= pack_next;
            warn_reg <= warn_next;
            crit_reg <= crit_next;
        end
    end

    // Output register.
    logic [ADC_BITS-1:0] raw_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            raw_out_reg <= in_sample_reg;
        end
    end

    // The filter state always equals the last result, so it doubles as the
    // result payload.
    assign m_valid     = out_valid_reg;
    assign m_raw_level = raw_out_reg;
    assign m_level     = avg_reg;
    assign m_pack      = pack_reg;
    assign m_warn      = warn_reg;
    assign m_crit      = crit_reg;

    // A result shows an unknown pack exactly when its level is zero.
    a_unknown_iff_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_level == '0) == (m_pack == PACK_UNKNOWN)))
        else $error("pack type and zero level disagree");

    // An unknown pack forces both low flags on.
    a_unknown_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_pack == PACK_UNKNOWN)) |-> (m_warn && m_crit))
        else $error("unknown pack without both flags set");

    // A critical flag that is set while the warning is clear needs a critical
    // limit above the warning one, so check the simpler invariant: the
    // filter state only moves when a sample leaves the input register.
    a_state_moves_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(avg_reg) && $stable(pack_reg))
        else $error("filter state changed without a sample");

    // An input beat held back means the result side is full and stalled.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |-> (out_valid_reg && !m_ready))
        else $error("input stage stalled without a result stall");

endmodule
